[src/egar_pkg.sv]
package egar_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned SquareW    = 31;
  localparam int unsigned EnergyW    = 41;
  localparam int unsigned ChunkLenW  = 11;
  localparam int unsigned SilentW    = 8;
  localparam int unsigned BufferedW  = 12;
  localparam int unsigned AvailW     = 16;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgValueW  = 41;

  localparam int unsigned ChunkLengthReset     = 160;
  localparam logic [EnergyW-1:0]   EnergyThresholdReset = 41'd17179869;
  localparam logic [SilentW-1:0]   SilentLimitReset     = 8'd200;
  localparam logic [BufferedW-1:0] MaxBufferedReset     = 12'd3000;

  typedef enum logic {
    OpPush = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgChunkLength     = 2'd0,
    CfgEnergyThreshold = 2'd1,
    CfgSilentLimit     = 2'd2,
    CfgMaxBuffered     = 2'd3
  } cfg_index_e;

  typedef struct packed {
    op_e                       op;
    logic signed [SampleW-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic                      is_read_reply;
    logic signed [SampleW-1:0] sample_out;
    logic                      read_valid;
    logic                      chunk_silent;
    logic                      recording_now;
    logic [BufferedW-1:0]      released_chunks;
    logic [AvailW-1:0]         available_count;
  } out_item_t;

  typedef struct packed {
    cfg_index_e            index;
    logic [CfgValueW-1:0]  value;
  } cfg_req_t;

  typedef struct packed {
    logic [EnergyW-1:0]   energy_threshold;
    logic [SilentW-1:0]   silent_chunk_limit;
    logic [BufferedW-1:0] max_buffered_chunks;
  } gate_cfg_t;

  typedef struct packed {
    logic [EnergyW-1:0]   energy_sum;
    logic [SilentW-1:0]   silent_run;
    logic                 recording;
    logic [BufferedW-1:0] buffered;
    logic [AvailW-1:0]    available;
  } chunk_state_t;

  typedef struct packed {
    logic                 silent;
    logic                 advance;
    logic [BufferedW-1:0] released;
    logic [EnergyW-1:0]   energy_acc;
    chunk_state_t         next;
  } chunk_dec_t;

endpackage

[src/egar_chan_if.sv]
interface egar_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[src/energy_gated_audio_recorder.sv]
// Energy-gated audio recorder.
// Three valid/ready channels: in_i carries requests (push one sample or
// read one sample), out_o carries results, and cfg_i writes the four
// configuration registers. A push that completes a chunk yields a chunk
// report; every read yields a read reply; other pushes yield nothing.
// A request is squared in the first stage and applied to the recorder
// state and the ring memory in the second; its result sits in the output
// register from the cycle after that, and one request is taken every cycle
// while the output side keeps up.
// The ring is a single-port-per-direction synchronous memory of
// RING_DEPTH samples; the sample for a read reply comes from its
// registered read port. The ring is not cleared at reset; all counters,
// pointers and flags clear and the registers take their default values.
// When the receiver stalls, the reply waits in the output register, one
// further request is held in the first stage, and pushes that produce no
// result keep flowing; a request that produces a result waits for the
// output register to free up.
module energy_gated_audio_recorder #(
  parameter int unsigned RING_DEPTH = 1048576,
  parameter int unsigned MAX_CHUNK  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  egar_chan_if.sink   in_i,
  egar_chan_if.source out_o,
  egar_chan_if.sink   cfg_i
);
  import egar_pkg::*;

  localparam int unsigned AddrW       = $clog2(RING_DEPTH);
  localparam int unsigned LenW        = $clog2(MAX_CHUNK + 1);
  localparam int unsigned LenReset    = (ChunkLengthReset > MAX_CHUNK) ? MAX_CHUNK
                                                                    : ChunkLengthReset;
  localparam int unsigned LenResetMod = LenReset % RING_DEPTH;

  logic [SampleW-1:0] ring_mem [RING_DEPTH];
  logic [SampleW-1:0] rd_data_q;

  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] len_mod_q;
  gate_cfg_t        gate_cfg_q;
  logic [LenW-1:0]  len_new;
  logic [AddrW-1:0] len_mod_new;

  logic               s1_valid_q;
  in_item_t           s1_item_q;
  logic [SquareW-1:0] s1_square_q;
  logic signed [2*SampleW-1:0] sample_wide;
  logic [2*SampleW-1:0] square_full;

  logic      s2_valid_q, s2_valid_d;
  out_item_t res_q, res_d;

  chunk_state_t st_q, st_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] slot_q, slot_d;
  logic [AddrW-1:0] rp_q, rp_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  rpos_q, rpos_d;

  chunk_dec_t dec;
  logic [LenW-1:0]  pos_inc;
  logic [LenW-1:0]  rpos_inc;
  logic             chunk_end;
  logic             s1_has_result;
  logic             s2_free;
  logic             s1_adv;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW:0]   wp_sum;
  logic [AddrW-1:0] wp_adv;
  logic [AddrW-1:0] slot_inc;
  logic [AddrW-1:0] rp_inc;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    int unsigned t;
    if (cfg_i.data.value[ChunkLenW-1:0] == '0) begin
      t = 1;
    end else if (32'(cfg_i.data.value[ChunkLenW-1:0]) > MAX_CHUNK) begin
      t = MAX_CHUNK;
    end else begin
      t = 32'(cfg_i.data.value[ChunkLenW-1:0]);
    end
    len_new = LenW'(t);
    for (int k = 0; k < 4; k++) begin
      if (t >= RING_DEPTH) begin
        t = t - RING_DEPTH;
      end
    end
    len_mod_new = AddrW'(t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q                          <= LenW'(LenReset);
      len_mod_q                      <= AddrW'(LenResetMod);
      gate_cfg_q.energy_threshold    <= EnergyThresholdReset;
      gate_cfg_q.silent_chunk_limit  <= SilentLimitReset;
      gate_cfg_q.max_buffered_chunks <= MaxBufferedReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CfgChunkLength: begin
          len_q     <= len_new;
          len_mod_q <= len_mod_new;
        end
        CfgEnergyThreshold: gate_cfg_q.energy_threshold <= cfg_i.data.value[EnergyW-1:0];
        CfgSilentLimit: gate_cfg_q.silent_chunk_limit <= cfg_i.data.value[SilentW-1:0];
        CfgMaxBuffered: gate_cfg_q.max_buffered_chunks <= cfg_i.data.value[BufferedW-1:0];
        default: ;
      endcase
    end
  end

  assign sample_wide = (2*SampleW)'($signed(in_i.data.sample_in));
  assign square_full = $unsigned(sample_wide * sample_wide);

  assign pos_inc       = pos_q + 1'b1;
  assign rpos_inc      = rpos_q + 1'b1;
  assign chunk_end     = pos_inc >= len_q;
  assign s1_has_result = (s1_item_q.op == OpRead) || chunk_end;
  assign s2_free       = !s2_valid_q || out_o.ready;
  assign s1_adv        = s1_valid_q && (!s1_has_result || s2_free);
  assign in_i.ready    = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q   <= in_i.data;
      s1_square_q <= square_full[SquareW-1:0];
    end
  end

  egar_chunk_dec u_chunk_dec (
    .st_i     (st_q),
    .square_i (s1_square_q),
    .cfg_i    (gate_cfg_q),
    .dec_o    (dec)
  );

  always_comb begin
    wp_sum   = {1'b0, wp_q} + {1'b0, len_mod_q};
    wp_adv   = (wp_sum >= (AddrW+1)'(RING_DEPTH)) ? AddrW'(wp_sum - (AddrW+1)'(RING_DEPTH))
                                                   : wp_sum[AddrW-1:0];
    slot_inc = (slot_q == AddrW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    rp_inc   = (rp_q == AddrW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  end

  always_comb begin
    st_d   = st_q;
    wp_d   = wp_q;
    slot_d = slot_q;
    rp_d   = rp_q;
    pos_d  = pos_q;
    rpos_d = rpos_q;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    res_d  = '0;
    if (s1_adv) begin
      if (s1_item_q.op == OpRead) begin
        res_d.is_read_reply = 1'b1;
        if (st_q.available != '0) begin
          rd_en            = 1'b1;
          res_d.read_valid = 1'b1;
          rp_d             = rp_inc;
          if (rpos_inc >= len_q) begin
            rpos_d         = '0;
            st_d.available = st_q.available - 1'b1;
          end else begin
            rpos_d = rpos_inc;
          end
        end
        res_d.available_count = st_d.available;
      end else begin
        wr_en = 1'b1;
        if (chunk_end) begin
          st_d   = dec.next;
          pos_d  = '0;
          wp_d   = dec.advance ? wp_adv : wp_q;
          slot_d = dec.advance ? wp_adv : wp_q;
          res_d.chunk_silent    = dec.silent;
          res_d.recording_now   = dec.next.recording;
          res_d.released_chunks = dec.released;
          res_d.available_count = dec.next.available;
        end else begin
          st_d.energy_sum = dec.energy_acc;
          pos_d           = pos_inc;
          slot_d          = slot_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      wp_q   <= '0;
      slot_q <= '0;
      rp_q   <= '0;
      pos_q  <= '0;
      rpos_q <= '0;
    end else begin
      st_q   <= st_d;
      wp_q   <= wp_d;
      slot_q <= slot_d;
      rp_q   <= rp_d;
      pos_q  <= pos_d;
      rpos_q <= rpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[slot_q] <= s1_item_q.sample_in;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rp_q];
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_adv && s1_has_result) begin
      s2_valid_d = 1'b1;
    end else if (out_o.ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_result) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    out_o.data            = res_q;
    out_o.data.sample_out = res_q.read_valid ? rd_data_q : '0;
  end
  assign out_o.valid = s2_valid_q;

  a_read_valid_is_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.data.read_valid || out_o.data.is_read_reply))
    else $error("read_valid set on a chunk report");

  a_result_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_has_result) |-> s2_free)
    else $error("result overwrote a pending output");

  a_release_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.is_read_reply && out_o.data.released_chunks != '0)
      |-> !out_o.data.recording_now)
    else $error("chunks released while still recording");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, slot_q} < (AddrW+1)'(RING_DEPTH)) && ({1'b0, rp_q} < (AddrW+1)'(RING_DEPTH)))
    else $error("ring pointer beyond depth");

endmodule

[src/egar_chunk_dec.sv]
module egar_chunk_dec (
  input  egar_pkg::chunk_state_t             st_i,
  input  logic [egar_pkg::SquareW-1:0]       square_i,
  input  egar_pkg::gate_cfg_t                cfg_i,
  output egar_pkg::chunk_dec_t               dec_o
);
  import egar_pkg::*;

  logic [EnergyW:0]   sum_ext;
  logic [EnergyW-1:0] energy_acc;
  logic               silent;
  logic [SilentW-1:0] run_inc;
  logic [SilentW-1:0] run_n;
  logic               rec1;
  logic               rec2;
  logic               release_now;
  logic [BufferedW-1:0] buf_inc;
  logic [BufferedW-1:0] buf_n;
  logic [AvailW:0]      avail_sum;
  logic [AvailW-1:0]    avail_n;
  logic [BufferedW-1:0] released;

  always_comb begin
    sum_ext    = {1'b0, st_i.energy_sum} + (EnergyW+1)'(square_i);
    energy_acc = sum_ext[EnergyW] ? '1 : sum_ext[EnergyW-1:0];
    silent     = energy_acc < cfg_i.energy_threshold;
    run_inc    = (st_i.silent_run != '1) ? st_i.silent_run + 1'b1 : st_i.silent_run;

    release_now = 1'b0;
    run_n       = '0;
    rec1        = st_i.recording;
    if (silent) begin
      run_n = run_inc;
      if (run_inc >= cfg_i.silent_chunk_limit) begin
        run_n = '0;
        if (st_i.recording) begin
          rec1        = 1'b0;
          release_now = 1'b1;
        end
      end
    end else begin
      rec1 = 1'b1;
    end

    buf_inc = st_i.buffered;
    rec2    = rec1;
    if (rec1) begin
      buf_inc = (st_i.buffered != '1) ? st_i.buffered + 1'b1 : st_i.buffered;
      if (buf_inc >= cfg_i.max_buffered_chunks) begin
        rec2        = 1'b0;
        release_now = 1'b1;
      end
    end

    avail_sum = {1'b0, st_i.available} + (AvailW+1)'(buf_inc);
    avail_n   = st_i.available;
    buf_n     = buf_inc;
    released  = '0;
    if (release_now) begin
      released = buf_inc;
      avail_n  = avail_sum[AvailW] ? '1 : avail_sum[AvailW-1:0];
      buf_n    = '0;
    end

    dec_o.silent          = silent;
    dec_o.advance         = rec1;
    dec_o.released        = released;
    dec_o.energy_acc      = energy_acc;
    dec_o.next.energy_sum = '0;
    dec_o.next.silent_run = run_n;
    dec_o.next.recording  = rec2;
    dec_o.next.buffered   = buf_n;
    dec_o.next.available  = avail_n;
  end

endmodule
